// File: hw/rtl/swsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsc_pkg: shared types and codes of the sliding window sample cache
// Transaction payloads, command and status codes, register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package swsc_pkg;

    // input transaction command codes
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_PAN    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd_code;

    // result status codes
    localparam logic [1:0] ST_MISS    = 2'd0;
    localparam logic [1:0] ST_HIT     = 2'd1;
    localparam logic [1:0] ST_UNCACHE = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CACHE_ENABLE    = 2'd0;
    localparam logic [1:0] REG_PLOT_MODE       = 2'd1;
    localparam logic [1:0] REG_STEP_RECIPROCAL = 2'd2;
    localparam logic [1:0] REG_HIT_TOLERANCE   = 2'd3;

    // configuration reset values
    localparam logic [31:0] STEP_RECIP_RESET = 32'h0001_0000;
    localparam logic [14:0] HIT_TOL_RESET    = 15'd66;

    // what a pan or clear leaves to do on the valid bits
    typedef enum logic [1:0] {
        SWEEP_NONE,
        SWEEP_WALK,
        SWEEP_WIPE
    } t_sweep;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] param_t;
        logic [31:0]        fill_x;
        logic [31:0]        fill_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] value_x;
        logic [31:0] value_y;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic rnd;
        logic eval;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic walk;
        logic wipe;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd_code op;
        logic      uncache;
        t_sweep    sweep;
        logic      plot_mode;
        logic      walk_done;
        logic      wipe_last;
        logic      out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// File: hw/rtl/swsc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsc_dp: datapath of the sliding window sample cache
// Configuration registers, origin and ring start, the grid index multiply
// and rounding, value and valid memories, and the output register.
// ----------------------------------------------------------------------------
module swsc_dp #(
    parameter int CACHE_SLOTS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  swsc_pkg::t_in_item    i_in_data,
    input  logic                  i_out_ready,
    input  swsc_pkg::t_dp_cmd     i_cmd,
    output swsc_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output swsc_pkg::t_out_item   o_out_data
);
    import swsc_pkg::*;

    localparam int              SW       = $clog2(CACHE_SLOTS);
    localparam int              HALF     = CACHE_SLOTS / 2;
    localparam logic [SW:0]     N_EXT    = CACHE_SLOTS[SW:0];
    localparam logic [SW-1:0]   LAST     = SW'(CACHE_SLOTS - 1);
    localparam logic [32:0]     WIN_FULL = 33'(CACHE_SLOTS);
    localparam logic [32:0]     WIN_HALF = 33'(HALF);

    // storage
    logic [31:0] mem_value [CACHE_SLOTS];
    logic        mem_valid [CACHE_SLOTS];

    // configuration and persistent state
    logic               r_cache_enable;
    logic               r_plot_mode;
    logic [31:0]        r_step_recip;
    logic [14:0]        r_hit_tol;
    logic [SW-1:0]      r_ring_start;
    logic signed [31:0] r_origin;

    // per-transaction registers
    t_cmd_code          r_op;
    logic signed [31:0] r_t;
    logic [31:0]        r_fill_x;
    logic [31:0]        r_fill_y;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic               r_zero;
    logic [63:0]        r_prod;
    logic [32:0]        r_idx;
    logic               r_off;
    logic               r_uncache;
    logic [SW-1:0]      r_slot;
    logic [SW-1:0]      r_addr_a;
    logic [SW-1:0]      r_addr_b;
    t_sweep             r_sweep;
    logic [SW-1:0]      r_ptr;
    logic [SW-1:0]      r_cnt;
    logic [31:0]        r_rd_value;
    logic               r_rd_ok;
    logic [31:0]        r_xa_value;
    logic               r_xa_ok;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    // combinational intermediates
    logic signed [32:0] diff_fwd;
    logic signed [32:0] diff_back;
    logic [63:0]        prod;
    logic [31:0]        frac;
    logic [31:0]        grid_dist;
    logic [SW-1:0]      pt;
    logic [SW:0]        sum_fwd;
    logic [SW:0]        fwd_wrap;
    logic [SW:0]        back_raw;
    logic [SW:0]        back_wrap;
    logic [SW-1:0]      rs_fwd;
    logic [SW-1:0]      rs_back;
    logic               in_window;
    logic               pan_fits;
    logic               step_zero;
    logic [SW-1:0]      ptr_next;
    logic [SW-1:0]      rd_addr;
    logic               val_we;
    logic [SW-1:0]      val_waddr;
    logic [31:0]        val_wdata;
    logic               vld_we;
    logic [SW-1:0]      vld_waddr;
    logic               vld_wdata;
    logic               hit;

    // origin difference, both directions so the magnitude needs no negate
    assign diff_fwd  = {i_in_data.param_t[31], i_in_data.param_t} - {r_origin[31], r_origin};
    assign diff_back = {r_origin[31], r_origin} - {i_in_data.param_t[31], i_in_data.param_t};

    // 32x32 unsigned multiply
    assign prod = {32'd0, r_mag} * {32'd0, r_step_recip};

    // distance of the Q32.32 product from the nearest grid point
    assign frac      = r_prod[31:0];
    assign grid_dist = frac[31] ? (~frac + 32'd1) : frac;

    // ring arithmetic on the rounded index
    assign step_zero = (r_step_recip == 32'd0);
    assign pt        = r_idx[SW-1:0];
    assign sum_fwd   = {1'b0, pt} + {1'b0, r_ring_start};
    assign fwd_wrap  = (sum_fwd >= N_EXT) ? (sum_fwd - N_EXT) : sum_fwd;
    assign rs_fwd    = fwd_wrap[SW-1:0];
    assign back_raw  = {1'b0, r_ring_start} - {1'b0, pt};
    assign back_wrap = back_raw[SW] ? (back_raw + N_EXT) : back_raw;
    assign rs_back   = back_wrap[SW-1:0];
    assign in_window = r_plot_mode ? (r_idx < WIN_HALF) : (r_idx < WIN_FULL);
    assign pan_fits  = !r_off && (r_idx < WIN_FULL) && !r_plot_mode && !step_zero;

    assign ptr_next = (r_ptr == LAST) ? '0 : (r_ptr + 1'b1);
    assign rd_addr  = i_cmd.rd_b ? r_addr_b : r_addr_a;

    // value memory write port
    assign val_we    = i_cmd.wr_a || i_cmd.wr_b;
    assign val_waddr = i_cmd.wr_a ? r_addr_a : r_addr_b;
    assign val_wdata = i_cmd.wr_a ? r_fill_x : r_fill_y;

    // valid memory write port: fills set, walk and wipe clear
    assign vld_we    = i_cmd.wr_a || i_cmd.wr_b || i_cmd.walk || i_cmd.wipe;
    assign vld_waddr = i_cmd.wr_a ? r_addr_a : (i_cmd.wr_b ? r_addr_b : r_ptr);
    assign vld_wdata = i_cmd.wr_a || i_cmd.wr_b;

    // value memory, registered read
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            mem_value[val_waddr] <= val_wdata;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_rd_value <= mem_value[rd_addr];
        end
    end

    // valid memory, registered read
    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            mem_valid[vld_waddr] <= vld_wdata;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_rd_ok <= mem_valid[rd_addr];
        end
    end

    // configuration, ring state, sweep pointer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable <= 1'b0;
            r_plot_mode    <= 1'b0;
            r_step_recip   <= STEP_RECIP_RESET;
            r_hit_tol      <= HIT_TOL_RESET;
            r_ring_start   <= '0;
            r_origin       <= '0;
            r_ptr          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CACHE_ENABLE:    r_cache_enable <= i_cfg_data[0];
                    REG_PLOT_MODE:       r_plot_mode    <= i_cfg_data[0];
                    REG_STEP_RECIPROCAL: r_step_recip   <= i_cfg_data;
                    REG_HIT_TOLERANCE:   r_hit_tol      <= i_cfg_data[14:0];
                endcase
            end
            if (i_cmd.eval) begin
                unique case (r_op)
                    CMD_PAN: begin
                        if (!r_zero) begin
                            r_origin <= r_t;
                            if (pan_fits) begin
                                r_ring_start <= r_neg ? rs_back : rs_fwd;
                                r_ptr        <= r_neg ? rs_back : r_ring_start;
                            end else begin
                                r_ring_start <= '0;
                                r_ptr        <= '0;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        r_ring_start <= '0;
                        r_ptr        <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.walk || i_cmd.wipe) begin
                r_ptr <= ptr_next;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-transaction pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_cmd_code'(i_in_data.command);
            r_t      <= i_in_data.param_t;
            r_fill_x <= i_in_data.fill_x;
            r_fill_y <= i_in_data.fill_y;
            r_neg    <= diff_fwd[32];
            r_mag    <= diff_fwd[32] ? diff_back[31:0] : diff_fwd[31:0];
            r_zero   <= (i_in_data.param_t == r_origin);
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.rnd) begin
            r_idx <= {1'b0, r_prod[63:32]} + {32'd0, r_prod[31]};
            r_off <= grid_dist > {1'b0, r_hit_tol, 16'd0};
        end
        if (i_cmd.eval) begin
            r_uncache <= !r_cache_enable || step_zero || r_neg || r_off || !in_window;
            r_slot    <= r_plot_mode ? pt : rs_fwd;
            r_addr_a  <= r_plot_mode ? {pt[SW-2:0], 1'b0} : rs_fwd;
            r_addr_b  <= r_plot_mode ? {pt[SW-2:0], 1'b1} : rs_fwd;
            r_cnt     <= pt;
            unique case (r_op)
                CMD_PAN:   r_sweep <= r_zero ? SWEEP_NONE
                                      : (pan_fits ? SWEEP_WALK : SWEEP_WIPE);
                CMD_CLEAR: r_sweep <= SWEEP_WIPE;
                default:   r_sweep <= SWEEP_NONE;
            endcase
        end else if (i_cmd.walk) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.rd_b) begin
            r_xa_value <= r_rd_value;
            r_xa_ok    <= r_rd_ok;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    // result formation
    assign hit = r_xa_ok && r_rd_ok;

    always_comb begin
        n_out.status  = ST_UNCACHE;
        n_out.slot    = 8'd0;
        n_out.value_x = 32'd0;
        n_out.value_y = 32'd0;
        unique case (r_op)
            CMD_LOOKUP: begin
                if (!r_uncache) begin
                    n_out.slot = 8'(r_slot);
                    if (hit) begin
                        n_out.status  = ST_HIT;
                        n_out.value_x = r_plot_mode ? r_xa_value : 32'd0;
                        n_out.value_y = r_rd_value;
                    end else begin
                        n_out.status = ST_MISS;
                    end
                end
            end
            CMD_FILL: begin
                if (!r_uncache) begin
                    n_out.status = ST_DONE;
                    n_out.slot   = 8'(r_slot);
                end
            end
            CMD_PAN, CMD_CLEAR: begin
                n_out.status = ST_DONE;
                n_out.slot   = 8'(r_ring_start);
            end
        endcase
    end

    // status toward the controller
    assign o_status.op        = r_op;
    assign o_status.uncache   = r_uncache;
    assign o_status.sweep     = r_sweep;
    assign o_status.plot_mode = r_plot_mode;
    assign o_status.walk_done = (r_cnt == '0);
    assign o_status.wipe_last = (r_ptr == LAST);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/swsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsc_ctrl: controller of the sliding window sample cache
// Sequences one transaction at a time through multiply, rounding, window
// check, memory access or valid-bit sweep, and the output register.
// ----------------------------------------------------------------------------
module swsc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  swsc_pkg::t_dp_status  i_status,
    output swsc_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_ready
);
    import swsc_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MUL,
        S_RND,
        S_EVAL,
        S_DISP,
        S_RDA,
        S_RDB,
        S_WRA,
        S_WRB,
        S_WALK,
        S_WIPE,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wipe = 1'b1;
                if (i_status.wipe_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DISP;
            end
            S_DISP: begin
                unique case (i_status.op)
                    CMD_LOOKUP: n_state = i_status.uncache ? S_RESP : S_RDA;
                    CMD_FILL: begin
                        priority if (i_status.uncache) begin
                            n_state = S_RESP;
                        end else if (i_status.plot_mode) begin
                            n_state = S_WRA;
                        end else begin
                            n_state = S_WRB;
                        end
                    end
                    CMD_PAN, CMD_CLEAR: begin
                        unique case (i_status.sweep)
                            SWEEP_WALK: n_state = S_WALK;
                            SWEEP_WIPE: n_state = S_WIPE;
                            default:    n_state = S_RESP;
                        endcase
                    end
                endcase
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_RESP;
            end
            S_WRA: begin
                o_cmd.wr_a = 1'b1;
                n_state    = S_WRB;
            end
            S_WRB: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_RESP;
            end
            S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_WIPE: begin
                o_cmd.wipe = 1'b1;
                if (i_status.wipe_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/sliding_window_sample_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_sample_cache: ring cache of sampled values indexed by t
// Lookup, fill, pan and clear transactions on a window of CACHE_SLOTS
// points, with a controller and a datapath holding one-read one-write memories.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. After the accept cycle, it steps
// through the 32x32 multiply, rounding, window check and dispatch states;
// a lookup then reads its two words through the single read port, a fill
// writes one word in single mode and two in pair mode, and an uncacheable
// lookup or fill and a pan to the same origin go straight to the response.
// A pan that stays on the grid clears the valid bit of each vacated slot one
// per cycle; a clear, or a pan that is off grid, too large, in pair mode or
// with a zero step reciprocal, sweeps all valid bits one per cycle. After
// reset the block runs the same sweep before it takes the first transaction;
// configuration writes are taken meanwhile. A finished result waits in the
// output register while the next transaction is accepted. The user must write
// configuration only while no transaction is open; this is not enforced.
module sliding_window_sample_cache #(
    parameter int CACHE_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  swsc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output swsc_pkg::t_out_item o_out_data
);
    import swsc_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    swsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_ready (o_in_ready)
    );

    // arithmetic, memories and output register
    swsc_dp #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: hw/rtl/swsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsc_checker: port-level checks of the sliding window sample cache
// Watches the top-level ports and flags output or handshake behavior that
// the cache never shows; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module swsc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  swsc_pkg::t_out_item o_out_data
);
    import swsc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // value words are zero unless the transaction hit
    a_values_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_HIT)
            |-> (o_out_data.value_x == 32'd0) && (o_out_data.value_y == 32'd0))
        else $error("value words set without a hit");

    // an uncacheable result carries slot zero
    a_uncache_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_UNCACHE) |-> (o_out_data.slot == 8'd0))
        else $error("uncacheable result with nonzero slot");

    // one transaction at a time: ready drops after an accept
    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted back to back");

endmodule

bind sliding_window_sample_cache swsc_checker u_swsc_checker (.*);
`default_nettype wire

// File: dv/sliding_window_sample_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sample_cache_tb: self-checking bench of the sample cache
// Drives lookup, fill, pan and clear transactions through valid/ready with
// random gaps and stalls, writes the four registers between phases, and
// checks every reply against a scripted reply or an in-bench ring cache model.
// ----------------------------------------------------------------------------
module sliding_window_sample_cache_tb;
    import swsc_pkg::*;

    localparam int CACHE_SLOTS   = 256;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int FINAL_CYCLES  = 300;
    localparam int REPORT_MAX    = 10;

    // one row of the directed script: a register write or a transaction
    typedef struct packed {
        logic        is_reg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        t_in_item    item;
        logic        has_reply;
        t_out_item   reply;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    // cache model state and register copies
    logic        slot_valid [CACHE_SLOTS];
    logic [31:0] slot_word  [CACHE_SLOTS];
    logic [7:0]  ring_base;
    logic [31:0] origin_q;
    logic        cfg_enable;
    logic        cfg_pair;
    logic [31:0] cfg_recip;
    logic [14:0] cfg_tol;

    t_out_item   replies_due [$];
    t_script_row script [$];
    int          error_count  = 0;
    int unsigned cycle_count  = 0;
    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;
    bit          rx_hold_req  = 1'b0;

    sliding_window_sample_cache #(
        .CACHE_SLOTS(CACHE_SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // run guard
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // cache model
    // ------------------------------------------------------------------------

    // scale a magnitude by the step reciprocal: rounded grid index, off-grid flag
    function automatic logic [32:0] to_grid(input logic [32:0] mag, output logic off);
        logic [64:0] prod;
        logic [31:0] frac;
        logic [32:0] grid_dist;
        prod      = 65'(mag) * 65'(cfg_recip);
        frac      = prod[31:0];
        grid_dist = frac[31] ? 33'h1_0000_0000 - 33'(frac) : 33'(frac);
        off       = grid_dist > {2'b00, cfg_tol, 16'h0000};
        return 33'((prod + 65'h8000_0000) >> 32);
    endfunction

    function automatic logic signed [32:0] t_minus_origin(input logic [31:0] t);
        return $signed({t[31], t}) - $signed({origin_q[31], origin_q});
    endfunction

    task automatic wipe_cache();
        ring_base = '0;
        for (int i = 0; i < CACHE_SLOTS; i++) slot_valid[i] = 1'b0;
    endtask

    // point index for t, -1 when the cache cannot serve it
    function automatic int point_of(input logic [31:0] t);
        logic signed [32:0] diff;
        logic [32:0]        idx;
        logic               off;
        int                 window;
        if (!cfg_enable || cfg_recip == 0) return -1;
        diff = t_minus_origin(t);
        if (diff < 0) return -1;
        idx    = to_grid(33'(diff), off);
        window = cfg_pair ? CACHE_SLOTS / 2 : CACHE_SLOTS;
        if (off || idx >= 33'(window)) return -1;
        if (cfg_pair) return int'(idx);
        return (int'(idx) + int'(ring_base)) % CACHE_SLOTS;
    endfunction

    // move the origin, rotating the ring or dropping everything
    task automatic pan_to(input logic [31:0] t);
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic [32:0]        shift;
        logic               off;
        diff = t_minus_origin(t);
        if (diff == 0) return;
        origin_q = t;
        if (cfg_pair || cfg_recip == 0) begin
            wipe_cache();
            return;
        end
        mag   = (diff < 0) ? 33'(-diff) : 33'(diff);
        shift = to_grid(mag, off);
        if (off || shift >= 33'(CACHE_SLOTS)) begin
            wipe_cache();
            return;
        end
        if (diff > 0) begin
            for (int i = 0; i < int'(shift); i++)
                slot_valid[(int'(ring_base) + i) % CACHE_SLOTS] = 1'b0;
            ring_base = ring_base + shift[7:0];
        end else begin
            ring_base = ring_base - shift[7:0];
            for (int i = 0; i < int'(shift); i++)
                slot_valid[(int'(ring_base) + i) % CACHE_SLOTS] = 1'b0;
        end
    endtask

    // reply of one transaction, updating the model
    task automatic predict_reply(input t_in_item it, output t_out_item r);
        int p;
        int a;
        int b;
        r        = '0;
        r.status = ST_UNCACHE;
        case (it.command)
            CMD_LOOKUP, CMD_FILL: begin
                p = point_of(it.param_t);
                if (p >= 0) begin
                    r.slot = 8'(p);
                    a = cfg_pair ? (2 * p) % CACHE_SLOTS : p;
                    b = cfg_pair ? (2 * p + 1) % CACHE_SLOTS : p;
                    if (it.command == CMD_FILL) begin
                        if (cfg_pair) begin
                            slot_word[a]  = it.fill_x;
                            slot_valid[a] = 1'b1;
                        end
                        slot_word[b]  = it.fill_y;
                        slot_valid[b] = 1'b1;
                        r.status      = ST_DONE;
                    end else if (slot_valid[a] && slot_valid[b]) begin
                        r.status  = ST_HIT;
                        r.value_x = cfg_pair ? slot_word[a] : '0;
                        r.value_y = slot_word[b];
                    end else begin
                        r.status = ST_MISS;
                    end
                end
            end
            default: begin
                if (it.command == CMD_PAN) pan_to(it.param_t);
                else wipe_cache();
                r.status = ST_DONE;
                r.slot   = ring_base;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_script_row item_row(input t_cmd_code c, input logic [31:0] t,
                                             input logic [31:0] x, input logic [31:0] y);
        t_script_row r;
        r              = '0;
        r.item.command = c;
        r.item.param_t = t;
        r.item.fill_x  = x;
        r.item.fill_y  = y;
        return r;
    endfunction

    function automatic t_script_row known_row(input t_cmd_code c, input logic [31:0] t,
                                              input logic [31:0] x, input logic [31:0] y,
                                              input logic [1:0] st, input logic [7:0] sl,
                                              input logic [31:0] vx, input logic [31:0] vy);
        t_script_row r;
        r                 = item_row(c, t, x, y);
        r.has_reply       = 1'b1;
        r.reply.status    = st;
        r.reply.slot      = sl;
        r.reply.value_x   = vx;
        r.reply.value_y   = vy;
        return r;
    endfunction

    function automatic t_script_row reg_row(input logic [1:0] idx, input logic [31:0] val);
        t_script_row r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // parameter offset of k grid steps at the current step
    function automatic logic [31:0] grid_offset(input int k);
        longint unsigned ak;
        longint unsigned mag;
        if (cfg_recip == 0) return 32'(k) << 16;
        ak  = (k < 0) ? longint'(-k) : longint'(k);
        mag = ((ak << 32) + longint'(cfg_recip / 2)) / longint'(cfg_recip);
        return (k < 0) ? -mag[31:0] : mag[31:0];
    endfunction

    // mostly on grid, sometimes nudged around the tolerance
    function automatic logic [31:0] grid_jitter();
        if ($urandom_range(0, 3) != 0) return '0;
        return 32'($urandom_range(0, 200)) - 32'd100;
    endfunction

    function automatic t_in_item make_item();
        t_in_item it;
        int       roll;
        int       k;
        int       window;
        it.fill_x = $urandom;
        it.fill_y = $urandom;
        window    = cfg_pair ? CACHE_SLOTS / 2 : CACHE_SLOTS;
        roll      = $urandom_range(0, 99);
        if (roll < 4) k = -int'($urandom_range(1, 8));
        else if (roll < 10) k = window + int'($urandom_range(0, 8));
        else if (roll < 55) k = int'($urandom_range(0, 31));
        else k = int'($urandom_range(0, window - 1));
        it.param_t = origin_q + grid_offset(k) + grid_jitter();
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            it.command = CMD_LOOKUP;
        end else if (roll < 82) begin
            it.command = CMD_FILL;
        end else if (roll < 94) begin
            it.command = CMD_PAN;
            if ($urandom_range(0, 9) == 0) k = int'($urandom_range(0, 600)) - 300;
            else k = int'($urandom_range(0, 80)) - 40;
            it.param_t = origin_q + grid_offset(k) + grid_jitter();
        end else if (roll < 96) begin
            it.command = CMD_CLEAR;
        end else begin
            // noise: any command at any t
            it.command = 2'($urandom_range(0, 3));
            it.param_t = $urandom;
        end
        return it;
    endfunction

    // offer one transaction, predict its reply once accepted
    task automatic offer(input t_in_item it, input logic has_reply, input t_out_item reply);
        int        gap;
        t_out_item r;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_reply(it, r);
        replies_due.push_back(has_reply ? reply : r);
    endtask

    // stop offering and wait for every reply
    task automatic drain(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_CACHE_ENABLE:    cfg_enable = val[0];
            REG_PLOT_MODE:       cfg_pair   = val[0];
            REG_STEP_RECIPROCAL: cfg_recip  = val;
            default:             cfg_tol    = val[14:0];
        endcase
    endtask

    // ------------------------------------------------------------------------
    // reply checking
    // ------------------------------------------------------------------------
    task automatic check_reply(input t_out_item got);
        t_out_item want;
        if (replies_due.size() == 0) begin
            if (error_count < REPORT_MAX)
                $display("%0t: reply with none due: st=%0d slot=%0d x=%h y=%h",
                         $realtime, got.status, got.slot, got.value_x, got.value_y);
            error_count++;
            return;
        end
        want = replies_due.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.value_x !== want.value_x || got.value_y !== want.value_y) begin
            if (error_count < REPORT_MAX)
                $display({"%0t: reply mismatch: exp st=%0d slot=%0d x=%h y=%h, ",
                          "got st=%0d slot=%0d x=%h y=%h"},
                         $realtime, want.status, want.slot, want.value_x, want.value_y,
                         got.status, got.slot, got.value_x, got.value_y);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_reply(o_out_data);
    end

    // reply side: random stall per transaction, one long hold on request
    initial begin : reply_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req) begin
                stall       = LONG_HOLD;
                rx_hold_req = 1'b0;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 12);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic        en;
        logic        pair;
        logic [31:0] recip;
        logic [14:0] tol;
        int          n_items;

        // model reset
        wipe_cache();
        origin_q   = '0;
        cfg_enable = 1'b0;
        cfg_pair   = 1'b0;
        cfg_recip  = STEP_RECIP_RESET;
        cfg_tol    = HIT_TOL_RESET;

        // directed script
        script = '{
            // cache off after reset
            known_row(CMD_LOOKUP, 32'h0000_0000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            known_row(CMD_FILL,   32'h0001_0000, '1, '1, ST_UNCACHE, 8'd0, '0, '0),
            reg_row(REG_CACHE_ENABLE, 32'd1),
            known_row(CMD_LOOKUP, 32'h0000_0000, '0, '0, ST_MISS, 8'd0, '0, '0),
            known_row(CMD_FILL,   32'h0000_0000, '1, '1, ST_DONE, 8'd0, '0, '0),
            known_row(CMD_LOOKUP, 32'h0000_0000, '0, '0, ST_HIT, 8'd0, '0, '1),
            // last slot of the window, then just past it
            known_row(CMD_FILL,   32'h00FF_0000, '0, 32'hA5A5_A5A5, ST_DONE, 8'd255, '0, '0),
            known_row(CMD_LOOKUP, 32'h0100_0000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            // negative and extreme t
            known_row(CMD_LOOKUP, 32'hFFFF_0000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            known_row(CMD_LOOKUP, 32'h7FFF_FFFF, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            known_row(CMD_LOOKUP, 32'h8000_0000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            // half a step off grid, exactly at tolerance, one past it
            known_row(CMD_LOOKUP, 32'h0003_8000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            item_row(CMD_LOOKUP, 32'h0003_0042, '0, '0),
            item_row(CMD_LOOKUP, 32'h0003_0043, '0, '0),
            // pan forward, hit a shifted slot, pan to same origin, pan back
            item_row(CMD_PAN,    32'h0002_0000, '0, '0),
            item_row(CMD_LOOKUP, 32'h00FF_0000, '0, '0),
            item_row(CMD_PAN,    32'h0002_0000, '0, '0),
            item_row(CMD_PAN,    32'hFFFF_0000, '0, '0),
            // large pan, off-grid pan, clear
            item_row(CMD_PAN,    32'h03E8_0000, '0, '0),
            item_row(CMD_PAN,    32'h03E8_8000, '0, '0),
            known_row(CMD_CLEAR, 32'h0000_0000, '0, '0, ST_DONE, 8'd0, '0, '0),
            // pair mode: last point of the half window, then past it, then pan
            reg_row(REG_PLOT_MODE, 32'd1),
            item_row(CMD_FILL,   32'h0467_8000, 32'h1234_5678, 32'h9ABC_DEF0),
            item_row(CMD_LOOKUP, 32'h0467_8000, '0, '0),
            known_row(CMD_LOOKUP, 32'h0468_8000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            item_row(CMD_PAN,    32'h0000_0000, '0, '0),
            // zero step reciprocal
            reg_row(REG_STEP_RECIPROCAL, 32'd0),
            known_row(CMD_LOOKUP, 32'h0000_0000, '0, '0, ST_UNCACHE, 8'd0, '0, '0),
            item_row(CMD_PAN,    32'h0005_0000, '0, '0)
        };

        // synchronous reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_reg) begin
                drain(SETTLE_CYCLES);
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                offer(script[i].item, script[i].has_reply, script[i].reply);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 9; ph++) begin
            en      = 1'b1;
            pair    = 1'b0;
            recip   = 32'h0001_0000;
            tol     = 15'd66;
            n_items = 150;
            case (ph)
                0: n_items = 200;
                1: begin
                    recip = 32'h0010_0000;
                    tol   = 15'd0;
                end
                2: begin
                    pair = 1'b1;
                    tol  = 15'h7FFF;
                end
                3: begin
                    recip = 32'hFFFF_FFFF;
                    tol   = 15'($urandom_range(0, 32767));
                end
                4: begin
                    recip   = $urandom_range(32'h0000_1000, 32'h0040_0000);
                    tol     = 15'($urandom_range(0, 32767));
                    n_items = 200;
                end
                5: begin
                    pair  = 1'b1;
                    recip = $urandom_range(32'h0000_1000, 32'h0040_0000);
                end
                6: begin
                    en      = 1'b0;
                    n_items = 50;
                end
                7: begin
                    recip   = 32'd1;
                    tol     = 15'($urandom_range(0, 32767));
                    n_items = 50;
                end
                default: n_items = 100;
            endcase
            drain(SETTLE_CYCLES);
            write_reg(REG_CACHE_ENABLE, 32'(en));
            write_reg(REG_PLOT_MODE, 32'(pair));
            write_reg(REG_STEP_RECIPROCAL, recip);
            write_reg(REG_HIT_TOLERANCE, 32'(tol));
            for (int n = 0; n < n_items; n++) begin
                // alternate stretches with and without idling
                if (n % 40 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                // back up the block behind a held-off reply
                if (ph == 2 && n == 30) rx_hold_req = 1'b1;
                offer(make_item(), 1'b0, '0);
            end
        end

        drain(FINAL_CYCLES);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/swsc_pkg.sv
hw/rtl/swsc_dp.sv
hw/rtl/swsc_ctrl.sv
hw/rtl/sliding_window_sample_cache.sv
hw/rtl/swsc_checker.sv
dv/sliding_window_sample_cache_tb.sv
